[design/yprgb_pkg.sv]
package yprgb_pkg;

  // Chroma bytes carry an offset of half the byte range.
  localparam int unsigned CHROMA_OFFSET = 128;

  // Largest value of one color channel.
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Conversion coefficients as exact rationals: numerator / denominator.
  localparam longint unsigned RV_NUM = 1402;
  localparam longint unsigned RV_DEN = 1000;
  localparam longint unsigned GU_NUM = 34;
  localparam longint unsigned GU_DEN = 100;
  localparam longint unsigned GV_NUM = 714;
  localparam longint unsigned GV_DEN = 1000;
  localparam longint unsigned BU_NUM = 172;
  localparam longint unsigned BU_DEN = 100;

  // Headroom above the fraction bits in the color accumulators: eight bits
  // of luma, the chroma swing, the sign and a guard bit.
  localparam int unsigned ACC_HEAD = 13;

endpackage

[design/yprgb_pixel.sv]
module yprgb_pixel #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic [7:0]                              luma,
  input  logic signed [FRAC_BITS+yprgb_pkg::ACC_HEAD-1:0] red_term,
  input  logic signed [FRAC_BITS+yprgb_pkg::ACC_HEAD-1:0] green_term,
  input  logic signed [FRAC_BITS+yprgb_pkg::ACC_HEAD-1:0] blue_term,
  output logic [7:0]                              red,
  output logic [7:0]                              green,
  output logic [7:0]                              blue
);

  localparam int unsigned ACC_W = FRAC_BITS + yprgb_pkg::ACC_HEAD;

  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] red_acc;
  logic signed [ACC_W-1:0] green_acc;
  logic signed [ACC_W-1:0] blue_acc;

  // A sum at or below zero gives zero; otherwise the fraction is dropped
  // and anything at or above 256 saturates.
  function automatic logic [7:0] clamp_chan(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ACC_W-1] || acc == '0) begin
      res = '0;
    end else if (|acc[ACC_W-1:FRAC_BITS+8]) begin
      res = yprgb_pkg::CHAN_MAX;
    end else begin
      res = acc[FRAC_BITS+7:FRAC_BITS];
    end
    return res;
  endfunction

  assign base      = $signed({{(ACC_W-FRAC_BITS-8){1'b0}}, luma, {FRAC_BITS{1'b0}}});
  assign red_acc   = base + red_term;
  assign green_acc = base + green_term;
  assign blue_acc  = base + blue_term;

  assign red   = clamp_chan(red_acc);
  assign green = clamp_chan(green_acc);
  assign blue  = clamp_chan(blue_acc);

endmodule

[design/yuv_pair_to_rgb_with_skip.sv]
// YUV pair to RGB converter with change detection.
//
// Input channel (in_*): one transfer carries a horizontal pixel pair, two
// luma bytes with their shared U and V bytes, plus the same four bytes from
// the previous frame. Output channel (out_*): one transfer per input
// transfer, in order. out_tuser is the changed flag; when it is low the pair
// matched the previous frame and all six color bytes in out_tdata are zero.
// When it is high each pixel is converted with R = Y + 1.402 V,
// G = Y - 0.34 U - 0.714 V and B = Y + 1.72 U on centered chroma, with
// coefficients in fixed point of COEF_FRAC_BITS fraction bits, and each
// channel is clamped to 0..255 with the fraction truncated.
//
// The result passes through these register stages in order: centering
// and compare, chroma multiplies, chroma term combine, luma add and clamp,
// the last being the output register. Throughput is one pair per cycle
// as long as no stall on out_tready holds the output register back.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stall on out_tready fills the pipeline bubbles
// first and then pushes back to in_tready without dropping anything.
// Reset clears all valid bits; the output channel comes up empty.
module yuv_pair_to_rgb_with_skip #(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: luma_a, luma_b, chroma_u, chroma_v, prev_luma_a,
  // prev_luma_b, prev_chroma_u, prev_chroma_v (8 bits each).
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0 up: red_a, green_a, blue_a, red_b, green_b, blue_b
  // (8 bits each).
  output logic [47:0] out_tdata,
  // Field: changed (1 bit).
  output logic        out_tuser
);

  localparam int unsigned F      = COEF_FRAC_BITS;
  // Coefficients stay below two, so F+1 magnitude bits suffice; one spare.
  localparam int unsigned COEF_W = F + 2;
  localparam int unsigned PROD_W = COEF_W + 10;
  localparam int unsigned ACC_W  = F + yprgb_pkg::ACC_HEAD;

  // Round to nearest at elaboration.
  localparam longint unsigned COEF_RV =
    ((yprgb_pkg::RV_NUM << F) + yprgb_pkg::RV_DEN / 2) / yprgb_pkg::RV_DEN;
  localparam longint unsigned COEF_GU =
    ((yprgb_pkg::GU_NUM << F) + yprgb_pkg::GU_DEN / 2) / yprgb_pkg::GU_DEN;
  localparam longint unsigned COEF_GV =
    ((yprgb_pkg::GV_NUM << F) + yprgb_pkg::GV_DEN / 2) / yprgb_pkg::GV_DEN;
  localparam longint unsigned COEF_BU =
    ((yprgb_pkg::BU_NUM << F) + yprgb_pkg::BU_DEN / 2) / yprgb_pkg::BU_DEN;

  localparam logic [COEF_W-1:0] COEF_RV_C = COEF_RV[COEF_W-1:0];
  localparam logic [COEF_W-1:0] COEF_GU_C = COEF_GU[COEF_W-1:0];
  localparam logic [COEF_W-1:0] COEF_GV_C = COEF_GV[COEF_W-1:0];
  localparam logic [COEF_W-1:0] COEF_BU_C = COEF_BU[COEF_W-1:0];

  localparam logic [8:0] OFFSET_C = 9'(yprgb_pkg::CHROMA_OFFSET);

  // Input field split.
  logic [7:0] luma_a, luma_b, chroma_u, chroma_v;
  logic [7:0] prev_luma_a, prev_luma_b, prev_chroma_u, prev_chroma_v;

  assign luma_a        = in_tdata[7:0];
  assign luma_b        = in_tdata[15:8];
  assign chroma_u      = in_tdata[23:16];
  assign chroma_v      = in_tdata[31:24];
  assign prev_luma_a   = in_tdata[39:32];
  assign prev_luma_b   = in_tdata[47:40];
  assign prev_chroma_u = in_tdata[55:48];
  assign prev_chroma_v = in_tdata[63:56];

  // Handshake chain: a stage loads when it is empty or its successor moves.
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // Stage 1: centered chroma and change flag.
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_changed_r, s1_changed_nxt;
  logic signed [8:0] s1_u_r, s1_u_nxt;
  logic signed [8:0] s1_v_r, s1_v_nxt;
  logic [7:0]        s1_luma_a_r, s1_luma_b_r;

  // Stage 2: the four chroma products, shared by both pixels.
  logic                     s2_valid_r;
  logic                     s2_changed_r;
  logic [7:0]               s2_luma_a_r, s2_luma_b_r;
  logic signed [PROD_W-1:0] s2_rv_r, s2_rv_nxt;
  logic signed [PROD_W-1:0] s2_gu_r, s2_gu_nxt;
  logic signed [PROD_W-1:0] s2_gv_r, s2_gv_nxt;
  logic signed [PROD_W-1:0] s2_bu_r, s2_bu_nxt;

  // Stage 3: per-channel chroma terms at accumulator width.
  logic                    s3_valid_r;
  logic                    s3_changed_r;
  logic [7:0]              s3_luma_a_r, s3_luma_b_r;
  logic signed [ACC_W-1:0] s3_red_r, s3_red_nxt;
  logic signed [ACC_W-1:0] s3_green_r, s3_green_nxt;
  logic signed [ACC_W-1:0] s3_blue_r, s3_blue_nxt;

  // Stage 4: output register.
  logic        out_valid_r;
  logic [47:0] out_data_r, out_data_nxt;
  logic        out_changed_r;

  logic [7:0] red_a, green_a, blue_a, red_b, green_b, blue_b;

  assign s4_ready  = !out_valid_r || out_tready;
  assign s3_ready  = !s3_valid_r  || s4_ready;
  assign s2_ready  = !s2_valid_r  || s3_ready;
  assign s1_ready  = !s1_valid_r  || s2_ready;
  assign in_tready = s1_ready;

  // Stage 1 logic.
  always_comb begin
    s1_valid_nxt   = in_tvalid;
    s1_changed_nxt = !(luma_a == prev_luma_a && luma_b == prev_luma_b &&
                       chroma_u == prev_chroma_u && chroma_v == prev_chroma_v);
    s1_u_nxt       = $signed({1'b0, chroma_u} - OFFSET_C);
    s1_v_nxt       = $signed({1'b0, chroma_v} - OFFSET_C);
  end

  // Stage 2 logic: one narrow multiply per coefficient.
  always_comb begin
    s2_rv_nxt = $signed({1'b0, COEF_RV_C}) * s1_v_r;
    s2_gu_nxt = $signed({1'b0, COEF_GU_C}) * s1_u_r;
    s2_gv_nxt = $signed({1'b0, COEF_GV_C}) * s1_v_r;
    s2_bu_nxt = $signed({1'b0, COEF_BU_C}) * s1_u_r;
  end

  // Stage 3 logic: green takes both chroma products with negative sign.
  always_comb begin
    s3_red_nxt   = ACC_W'(s2_rv_r);
    s3_blue_nxt  = ACC_W'(s2_bu_r);
    s3_green_nxt = -(ACC_W'(s2_gu_r) + ACC_W'(s2_gv_r));
  end

  // Stage 4 logic: luma add and clamp for both pixels.
  yprgb_pixel #(
    .FRAC_BITS (F)
  ) u_pixel_a (
    .luma       (s3_luma_a_r),
    .red_term   (s3_red_r),
    .green_term (s3_green_r),
    .blue_term  (s3_blue_r),
    .red        (red_a),
    .green      (green_a),
    .blue       (blue_a)
  );

  yprgb_pixel #(
    .FRAC_BITS (F)
  ) u_pixel_b (
    .luma       (s3_luma_b_r),
    .red_term   (s3_red_r),
    .green_term (s3_green_r),
    .blue_term  (s3_blue_r),
    .red        (red_b),
    .green      (green_b),
    .blue       (blue_b)
  );

  always_comb begin
    if (s3_changed_r) begin
      out_data_nxt = {blue_b, green_b, red_b, blue_a, green_a, red_a};
    end else begin
      out_data_nxt = '0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r  <= s1_valid_nxt;
      if (s2_ready) s2_valid_r  <= s1_valid_r;
      if (s3_ready) s3_valid_r  <= s2_valid_r;
      if (s4_ready) out_valid_r <= s3_valid_r;
    end
  end

  // Payload registers load only with a transfer into the stage.
  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_changed_r <= s1_changed_nxt;
      s1_u_r       <= s1_u_nxt;
      s1_v_r       <= s1_v_nxt;
      s1_luma_a_r  <= luma_a;
      s1_luma_b_r  <= luma_b;
    end
    if (s2_ready && s1_valid_r) begin
      s2_changed_r <= s1_changed_r;
      s2_luma_a_r  <= s1_luma_a_r;
      s2_luma_b_r  <= s1_luma_b_r;
      s2_rv_r      <= s2_rv_nxt;
      s2_gu_r      <= s2_gu_nxt;
      s2_gv_r      <= s2_gv_nxt;
      s2_bu_r      <= s2_bu_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      s3_changed_r <= s2_changed_r;
      s3_luma_a_r  <= s2_luma_a_r;
      s3_luma_b_r  <= s2_luma_b_r;
      s3_red_r     <= s3_red_nxt;
      s3_green_r   <= s3_green_nxt;
      s3_blue_r    <= s3_blue_nxt;
    end
    if (s4_ready && s3_valid_r) begin
      out_changed_r <= s3_changed_r;
      out_data_r    <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_changed_r;

endmodule

[design/yprgb_checker.sv]
module yprgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An unchanged pair carries no colors.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 48'd0)
    else $error("unchanged pair with nonzero colors");

  // A receiver that takes results never holds back the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // The output comes up empty after reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // A pair equal to its previous frame, taken with the output draining
  // freely, comes out flagged unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[31:0] == in_tdata[63:32] &&
    out_tready ##1 out_tready ##1 out_tready ##1 out_tready
    |=> out_tvalid && !out_tuser)
    else $error("unchanged pair not reported");

endmodule

bind yuv_pair_to_rgb_with_skip yprgb_checker u_yprgb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[sim/tb_yuv_pair_to_rgb_with_skip.sv]
`timescale 1ns / 1ps

module tb_yuv_pair_to_rgb_with_skip;

  localparam int unsigned FRAC_BITS = 16;
  // Cycles in a row with no transfer on either channel before the run is
  // declared hung. The slowest legal quiet stretch is a long input gap plus
  // the pipeline depth plus a long output stall.
  localparam int unsigned STALL_LIMIT = 2000;
  // Extra cycles after the last result so that a stray result still shows up.
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_PAIRS = 800;
  localparam int unsigned BLOCK_PAIRS = 50;

  // One result: the changed flag and six color bytes. chan[0] is red_a and
  // chan[5] is blue_b, the same order as out_tdata from bit 0 up.
  typedef struct packed {
    logic            changed;
    logic [5:0][7:0] chan;
  } color_pair_t;

  // Holds the colors expected for each accepted pixel pair and checks the
  // results against them in order.
  class rgb_pair_checker;
    localparam longint K_RV = longint'(((yprgb_pkg::RV_NUM << FRAC_BITS) +
                                        yprgb_pkg::RV_DEN / 2) / yprgb_pkg::RV_DEN);
    localparam longint K_GU = longint'(((yprgb_pkg::GU_NUM << FRAC_BITS) +
                                        yprgb_pkg::GU_DEN / 2) / yprgb_pkg::GU_DEN);
    localparam longint K_GV = longint'(((yprgb_pkg::GV_NUM << FRAC_BITS) +
                                        yprgb_pkg::GV_DEN / 2) / yprgb_pkg::GV_DEN);
    localparam longint K_BU = longint'(((yprgb_pkg::BU_NUM << FRAC_BITS) +
                                        yprgb_pkg::BU_DEN / 2) / yprgb_pkg::BU_DEN);

    color_pair_t expected_colors[$];
    int unsigned mismatches;
    int unsigned pairs_noted;
    int unsigned unchanged_noted;
    int unsigned results_checked;

    function new();
      mismatches = 0;
      pairs_noted = 0;
      unchanged_noted = 0;
      results_checked = 0;
    endfunction

    // Zero or negative sums give black; otherwise drop the fraction and
    // saturate at full scale.
    static function logic [7:0] clamp_channel(longint acc);
      longint whole;
      if (acc <= 0) return 8'd0;
      whole = acc >>> FRAC_BITS;
      if (whole > 255) return yprgb_pkg::CHAN_MAX;
      return whole[7:0];
    endfunction

    static function color_pair_t convert_pair(logic [63:0] pair);
      color_pair_t res;
      longint u, v, base;
      res = '0;
      // The pair is skipped when all four bytes match the previous frame.
      if (pair[31:0] == pair[63:32]) return res;
      u = longint'(pair[23:16]) - longint'(yprgb_pkg::CHROMA_OFFSET);
      v = longint'(pair[31:24]) - longint'(yprgb_pkg::CHROMA_OFFSET);
      res.changed = 1'b1;
      for (int p = 0; p < 2; p++) begin
        base = longint'(pair[p*8 +: 8]) * (longint'(1) << FRAC_BITS);
        res.chan[p*3]     = clamp_channel(base + K_RV * v);
        res.chan[p*3 + 1] = clamp_channel(base - K_GU * u - K_GV * v);
        res.chan[p*3 + 2] = clamp_channel(base + K_BU * u);
      end
      return res;
    endfunction

    static function string field_name(int idx);
      case (idx)
        0: return "red_a";
        1: return "green_a";
        2: return "blue_a";
        3: return "red_b";
        4: return "green_b";
        default: return "blue_b";
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_pair(logic [63:0] pair);
      color_pair_t res;
      res = convert_pair(pair);
      pairs_noted++;
      if (!res.changed) unchanged_noted++;
      expected_colors.push_back(res);
    endfunction

    function void check_colors(logic [47:0] tdata, logic tuser);
      color_pair_t want;
      if (expected_colors.size() == 0) begin
        report($sformatf("Mismatch: result with nothing expected, changed=%b data=%h",
                         tuser, tdata));
        return;
      end
      want = expected_colors.pop_front();
      results_checked++;
      if (tuser !== want.changed)
        report($sformatf("Mismatch in result %0d: changed expected %b, got %b",
                         results_checked, want.changed, tuser));
      for (int i = 0; i < 6; i++) begin
        if (tdata[i*8 +: 8] !== want.chan[i])
          report($sformatf("Mismatch in result %0d: %s expected %0d, got %0d",
                           results_checked, field_name(i), want.chan[i],
                           tdata[i*8 +: 8]));
      end
    endfunction

    function int unsigned pending();
      return expected_colors.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // Fields from bit 0 up: luma_a, luma_b, chroma_u, chroma_v, prev_luma_a,
  // prev_luma_b, prev_chroma_u, prev_chroma_v.
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // Fields from bit 0 up: red_a, green_a, blue_a, red_b, green_b, blue_b.
  logic [47:0] out_tdata;
  // Field: changed.
  logic        out_tuser;

  // When set, neither side inserts gaps, so the pipeline runs at full rate.
  bit calm_phase = 1'b0;
  int unsigned quiet_cycles = 0;
  rgb_pair_checker colors = new();

  yuv_pair_to_rgb_with_skip #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Random byte that lands on the extremes or the chroma midpoint fairly often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [63:0] make_pair(logic [7:0] ya, logic [7:0] yb, logic [7:0] cu,
                                            logic [7:0] cv, logic [7:0] pya,
                                            logic [7:0] pyb, logic [7:0] pcu,
                                            logic [7:0] pcv);
    return {pcv, pcu, pyb, pya, cv, cu, yb, ya};
  endfunction

  // Presents one pair and returns at the edge where the transfer happens.
  task automatic send_pair(input logic [63:0] pair);
    int unsigned gap;
    gap = calm_phase ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pair;
    do @(posedge clk); while (!in_tready);
  endtask

  // Input and output monitors sample the values that stood before the edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) colors.note_pair(in_tdata);
    if (rst_n && out_tvalid && out_tready) colors.check_colors(out_tdata, out_tuser);
  end

  // Watchdog: the run is hung if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Result side: ready for a random run of cycles, then a random stall.
  initial begin : result_sink
    int unsigned run;
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      run = $urandom_range(12, 1);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = calm_phase ? 0 : pick_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] cur;
    logic [31:0] prev;
    int unsigned kind;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unchanged pairs: all zero, all ones, and ordinary content.
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255,
                        8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(make_pair(8'd17, 8'd200, 8'd90, 8'd170, 8'd17, 8'd200, 8'd90, 8'd170));
    // Fully opposite extremes in both directions: heavy clamping at both ends.
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0));
    // A change in just one current byte, one field at a time.
    send_pair(make_pair(8'd101, 8'd50, 8'd128, 8'd128, 8'd100, 8'd50, 8'd128, 8'd128));
    send_pair(make_pair(8'd100, 8'd51, 8'd128, 8'd128, 8'd100, 8'd50, 8'd128, 8'd128));
    send_pair(make_pair(8'd100, 8'd50, 8'd129, 8'd128, 8'd100, 8'd50, 8'd128, 8'd128));
    send_pair(make_pair(8'd100, 8'd50, 8'd128, 8'd127, 8'd100, 8'd50, 8'd128, 8'd128));
    // Neutral chroma with black and white luma: colors equal the luma.
    send_pair(make_pair(8'd0, 8'd255, 8'd128, 8'd128, 8'd1, 8'd255, 8'd128, 8'd128));
    // Opposing chroma extremes.
    send_pair(make_pair(8'd128, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    // Just over full scale on red, just under zero on blue and red.
    send_pair(make_pair(8'd255, 8'd0, 8'd127, 8'd129, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd1, 8'd254, 8'd128, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0));
    // Back-to-back identical changed pairs, then the same pair unchanged.
    send_pair(make_pair(8'd60, 8'd61, 8'd40, 8'd220, 8'd59, 8'd61, 8'd40, 8'd220));
    send_pair(make_pair(8'd60, 8'd61, 8'd40, 8'd220, 8'd59, 8'd61, 8'd40, 8'd220));
    send_pair(make_pair(8'd60, 8'd61, 8'd40, 8'd220, 8'd60, 8'd61, 8'd40, 8'd220));

    // Random pairs in blocks; about one block in four runs without gaps.
    for (int blk = 0; blk < RANDOM_PAIRS / BLOCK_PAIRS; blk++) begin
      calm_phase = ($urandom_range(3) == 0);
      for (int i = 0; i < BLOCK_PAIRS; i++) begin
        cur = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        kind = $urandom_range(99);
        if (kind < 30) begin
          prev = cur;
        end else if (kind < 50) begin
          // Near miss: the previous frame differs in one bit only.
          prev = cur;
          prev[5'($urandom_range(31))] ^= 1'b1;
        end else begin
          prev = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        end
        send_pair({prev, cur});
      end
    end
    calm_phase = 1'b0;
    in_tvalid <= 1'b0;

    while (colors.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pixel pairs, %0d of them unchanged, with random gaps and stalls.",
             colors.pairs_noted, colors.unchanged_noted);
    $display("Results checked: %0d, field mismatches: %0d.",
             colors.results_checked, colors.mismatches);
    if (colors.mismatches == 0 && colors.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
design/yprgb_pkg.sv
design/yprgb_pixel.sv
design/yuv_pair_to_rgb_with_skip.sv
design/yprgb_checker.sv
sim/tb_yuv_pair_to_rgb_with_skip.sv
